// ===== rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg: shared definitions for the segment intersection test
// Field widths, the default coordinate width, verdict codes and the flag
// bundle that travels down the pipeline next to the products.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int FIELD_WIDTH     = 32;
	localparam int ID_WIDTH        = 32;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int NUM_COORDS      = 8;
	localparam int NUM_IDS         = 4;
	localparam int NUM_ORIENT      = 4;

	typedef enum logic [1:0] {
		REASON_CROSS  = 2'd0,
		REASON_BOX    = 2'd1,
		REASON_SHARED = 2'd2,
		REASON_ORIENT = 2'd3
	} sit_reason_t;

	// Early decisions that take priority over the orientation test.
	typedef struct packed {
		logic box_fail;
		logic shared;
	} sit_flags_t;

endpackage

// ===== rtl/sit_front.sv =====
// ----------------------------------------------------------------------------
// sit_front: first pipeline stage
// Box overlap test, shared vertex test and the coordinate differences
// needed by the four orientation determinants.
// ----------------------------------------------------------------------------
module sit_front #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  logic [sit_pkg::NUM_COORDS-1:0][sit_pkg::FIELD_WIDTH-1:0] coord,
	input  logic [sit_pkg::NUM_IDS-1:0][sit_pkg::ID_WIDTH-1:0] ids,
	output logic valid_s1,
	output sit_pkg::sit_flags_t flags_s1,
	output logic [sit_pkg::NUM_ORIENT-1:0][3:0][COORD_WIDTH:0] diff_s1
);

	logic signed [COORD_WIDTH-1:0] px [4];
	logic signed [COORD_WIDTH-1:0] py [4];
	logic signed [COORD_WIDTH-1:0] fx_hi, fx_lo, fy_hi, fy_lo;
	logic signed [COORD_WIDTH-1:0] sx_hi, sx_lo, sy_hi, sy_lo;
	sit_pkg::sit_flags_t flags;
	logic [sit_pkg::NUM_ORIENT-1:0][3:0][COORD_WIDTH:0] diff;

	function automatic logic [COORD_WIDTH:0] sub(input logic [COORD_WIDTH-1:0] p,
		input logic [COORD_WIDTH-1:0] q);
		return {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
	endfunction

	// Differences for orientation (a, b, c): a.x-c.x, b.y-c.y, a.y-c.y, b.x-c.x.
	function automatic logic [3:0][COORD_WIDTH:0] orient_diffs(input int a, input int b,
		input int c);
		logic [3:0][COORD_WIDTH:0] d;
		d[0] = sub(px[a], px[c]);
		d[1] = sub(py[b], py[c]);
		d[2] = sub(py[a], py[c]);
		d[3] = sub(px[b], px[c]);
		return d;
	endfunction

	always_comb begin
		for (int p = 0; p < 4; p++) begin
			px[p] = coord[2*p][COORD_WIDTH-1:0];
			py[p] = coord[2*p+1][COORD_WIDTH-1:0];
		end
		fx_hi = (px[0] > px[1]) ? px[0] : px[1];
		fx_lo = (px[0] < px[1]) ? px[0] : px[1];
		fy_hi = (py[0] > py[1]) ? py[0] : py[1];
		fy_lo = (py[0] < py[1]) ? py[0] : py[1];
		sx_hi = (px[2] > px[3]) ? px[2] : px[3];
		sx_lo = (px[2] < px[3]) ? px[2] : px[3];
		sy_hi = (py[2] > py[3]) ? py[2] : py[3];
		sy_lo = (py[2] < py[3]) ? py[2] : py[3];
		flags.box_fail = (fx_hi < sx_lo) || (sx_hi < fx_lo) ||
			(fy_hi < sy_lo) || (sy_hi < fy_lo);
		flags.shared = (ids[0] == ids[2]) || (ids[0] == ids[3]) ||
			(ids[1] == ids[2]) || (ids[1] == ids[3]);
		diff[0] = orient_diffs(0, 1, 2);
		diff[1] = orient_diffs(0, 1, 3);
		diff[2] = orient_diffs(2, 3, 0);
		diff[3] = orient_diffs(2, 3, 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= flags;
			diff_s1  <= diff;
		end
	end

endmodule

// ===== rtl/sit_mult.sv =====
// ----------------------------------------------------------------------------
// sit_mult: second pipeline stage
// Eight exact signed products, two for each orientation determinant.
// ----------------------------------------------------------------------------
module sit_mult #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s1,
	input  sit_pkg::sit_flags_t flags_s1,
	input  logic [sit_pkg::NUM_ORIENT-1:0][3:0][COORD_WIDTH:0] diff_s1,
	output logic valid_s2,
	output sit_pkg::sit_flags_t flags_s2,
	output logic [sit_pkg::NUM_ORIENT-1:0][1:0][2*COORD_WIDTH+1:0] prod_s2
);

	logic [sit_pkg::NUM_ORIENT-1:0][1:0][2*COORD_WIDTH+1:0] prod;
	logic signed [2*COORD_WIDTH+1:0] p_lhs, p_rhs;

	always_comb begin
		prod = '0;
		for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
			p_lhs = $signed(diff_s1[k][0]) * $signed(diff_s1[k][1]);
			p_rhs = $signed(diff_s1[k][2]) * $signed(diff_s1[k][3]);
			prod[k][0] = p_lhs;
			prod[k][1] = p_rhs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2 <= flags_s1;
			prod_s2  <= prod;
		end
	end

endmodule

// ===== rtl/sit_judge.sv =====
// ----------------------------------------------------------------------------
// sit_judge: third pipeline stage and output register
// Orientation signs from the product compares and the final verdict.
// ----------------------------------------------------------------------------
module sit_judge #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s2,
	input  sit_pkg::sit_flags_t flags_s2,
	input  logic [sit_pkg::NUM_ORIENT-1:0][1:0][2*COORD_WIDTH+1:0] prod_s2,
	output logic valid_s3,
	output logic hit_s3,
	output sit_pkg::sit_reason_t reason_s3
);

	logic [sit_pkg::NUM_ORIENT-1:0] pos;
	logic hit;
	sit_pkg::sit_reason_t reason;

	always_comb begin
		// A zero determinant counts as positive, hence the non-strict compare.
		for (int k = 0; k < sit_pkg::NUM_ORIENT; k++) begin
			pos[k] = $signed(prod_s2[k][1]) >= $signed(prod_s2[k][0]);
		end
		hit = 1'b0;
		if (flags_s2.box_fail) begin
			reason = sit_pkg::REASON_BOX;
		end else if (flags_s2.shared) begin
			reason = sit_pkg::REASON_SHARED;
		end else if ((pos[0] != pos[1]) && (pos[2] != pos[3])) begin
			reason = sit_pkg::REASON_CROSS;
			hit    = 1'b1;
		end else begin
			reason = sit_pkg::REASON_ORIENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3    <= hit;
			reason_s3 <= reason;
		end
	end

endmodule

// ===== rtl/segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test: pipelined 2D segment crossing test
// Decides whether two segments cross, with a reason code for the verdict.
//
// The item channel (item_valid / item_stall) carries one transaction per
// segment pair: four signed 16.16 coordinates and two vertex ids for each
// segment. The result channel (result_valid / result_stall) returns one
// transaction per pair: intersects and verdict_reason, in the order the
// pairs were taken.
//
// A new pair can be accepted in every cycle while item_stall is low; the
// three register stages (box and id tests with differences, the eight
// products, the compares and verdict) lie between acceptance and
// result_valid, the multiplier stage being the deepest.
//
// Reset clears the stage valid bits only; the data registers are not
// reset. When the receiver stalls, the result is held and the pipeline
// keeps filling any empty stages, so item_stall rises only once every
// stage holds a transaction.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] first_start_x,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] first_start_y,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] first_end_x,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] first_end_y,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] second_start_x,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] second_start_y,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] second_end_x,
	input  logic signed [sit_pkg::FIELD_WIDTH-1:0] second_end_y,
	input  logic [sit_pkg::ID_WIDTH-1:0] first_start_id,
	input  logic [sit_pkg::ID_WIDTH-1:0] first_end_id,
	input  logic [sit_pkg::ID_WIDTH-1:0] second_start_id,
	input  logic [sit_pkg::ID_WIDTH-1:0] second_end_id,
	output logic result_valid,
	input  logic result_stall,
	output logic intersects,
	output logic [1:0] verdict_reason
);

	logic [sit_pkg::NUM_COORDS-1:0][sit_pkg::FIELD_WIDTH-1:0] coord;
	logic [sit_pkg::NUM_IDS-1:0][sit_pkg::ID_WIDTH-1:0] ids;

	logic en1, en2, en3;
	logic valid_s1, valid_s2, valid_s3;
	sit_pkg::sit_flags_t flags_s1, flags_s2;
	logic [sit_pkg::NUM_ORIENT-1:0][3:0][COORD_WIDTH:0] diff_s1;
	logic [sit_pkg::NUM_ORIENT-1:0][1:0][2*COORD_WIDTH+1:0] prod_s2;
	logic hit_s3;
	sit_pkg::sit_reason_t reason_s3;

	// Points a, b (first segment) and c, d (second segment), x before y.
	assign coord = {second_end_y, second_end_x, second_start_y, second_start_x,
		first_end_y, first_end_x, first_start_y, first_start_x};
	assign ids = {second_end_id, second_start_id, first_end_id, first_start_id};

	// A stage advances when it is empty or the stage after it advances, so
	// bubbles are squeezed out even while the receiver holds the output.
	assign en3 = !valid_s3 || !result_stall;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign item_stall = !en1;

	sit_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.valid_in (item_valid),
		.coord    (coord),
		.ids      (ids),
		.valid_s1 (valid_s1),
		.flags_s1 (flags_s1),
		.diff_s1  (diff_s1)
	);

	sit_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.flags_s1 (flags_s1),
		.diff_s1  (diff_s1),
		.valid_s2 (valid_s2),
		.flags_s2 (flags_s2),
		.prod_s2  (prod_s2)
	);

	sit_judge #(.COORD_WIDTH(COORD_WIDTH)) u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en3),
		.valid_s2  (valid_s2),
		.flags_s2  (flags_s2),
		.prod_s2   (prod_s2),
		.valid_s3  (valid_s3),
		.hit_s3    (hit_s3),
		.reason_s3 (reason_s3)
	);

	assign result_valid   = valid_s3;
	assign intersects     = hit_s3;
	assign verdict_reason = reason_s3;

	// The input is held back only when every stage is occupied.
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("item_stall raised while a pipeline stage was empty");

	// A transaction leaving the middle stage must reach the output register.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en3) |=> result_valid)
		else $error("transaction lost between the product and verdict stages");

	// The crossing flag and the reason code must agree.
	a_flag_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (intersects == (verdict_reason == sit_pkg::REASON_CROSS)))
		else $error("intersects disagrees with verdict_reason");

endmodule
